/* rtl/ucn_pkg.sv */
// Package for the Unicode character normalizer: item types, run type, code constants
// and the halfwidth kana and width symbol tables.
// No dependencies.
package ucn_pkg;

  localparam int CpWidth   = 21;
  localparam int FifoDepth = 4;
  localparam int PtrWidth  = $clog2(FifoDepth);
  localparam int CntWidth  = $clog2(FifoDepth + 1);

  typedef logic [CpWidth-1:0] cp_t;

  typedef struct packed {
    cp_t  code_point;
    logic last_in_string;
  } in_item_t;

  typedef struct packed {
    cp_t  out_code_point;
    logic last_of_run;
  } out_item_t;

  // One classified input: up to two code points, then an optional terminator.
  typedef struct packed {
    cp_t        cp0;
    cp_t        cp1;
    logic [1:0] cnt;
  } run_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  localparam cp_t CpNul        = 21'h000000;
  localparam cp_t CpLf         = 21'h00000A;
  localparam cp_t CpCr         = 21'h00000D;
  localparam cp_t CpSpace      = 21'h000020;
  localparam cp_t CpNbsp       = 21'h0000A0;
  localparam cp_t CpFigSpace   = 21'h002007;
  localparam cp_t CpZwsp       = 21'h00200B;
  localparam cp_t CpWordJoin   = 21'h002060;
  localparam cp_t CpVoiced     = 21'h00309B;
  localparam cp_t CpSemiVoiced = 21'h00309C;
  localparam cp_t FullwidthOff = 21'h00FEE0;
  localparam cp_t VuOff        = 21'h00004E;
  localparam cp_t HalfKanaLo   = 21'h00FF5F;
  localparam cp_t WidthSymLo   = 21'h00FFE0;

  localparam int HalfKanaDepth = 66;
  localparam int HalfKanaIdxW  = $clog2(HalfKanaDepth);

  localparam logic [15:0] HalfKanaRom [HalfKanaDepth] = '{
    16'h2985,
    16'h2986, 16'h3002, 16'h300C, 16'h300D, 16'h3001, 16'h30FB, 16'h30F2, 16'h30A1,
    16'h30A3, 16'h30A5, 16'h30A7, 16'h30A9, 16'h30E3, 16'h30E5, 16'h30E7, 16'h30C3,
    16'h30FC, 16'h30A2, 16'h30A4, 16'h30A6, 16'h30A8, 16'h30AA, 16'h30AB, 16'h30AD,
    16'h30AF, 16'h30B1, 16'h30B3, 16'h30B5, 16'h30B7, 16'h30B9, 16'h30BB, 16'h30BD,
    16'h30BF, 16'h30C1, 16'h30C4, 16'h30C6, 16'h30C8, 16'h30CA, 16'h30CB, 16'h30CC,
    16'h30CD, 16'h30CE, 16'h30CF, 16'h30D2, 16'h30D5, 16'h30D8, 16'h30DB, 16'h30DE,
    16'h30DF, 16'h30E0, 16'h30E1, 16'h30E2, 16'h30E4, 16'h30E6, 16'h30E8, 16'h30E9,
    16'h30EA, 16'h30EB, 16'h30EC, 16'h30ED, 16'h30EF, 16'h30F3, 16'h309B, 16'h309C,
    16'h3164
  };

  localparam logic [15:0] WidthSymRom [16] = '{
    16'h00A2, 16'h00A3, 16'h00AC, 16'h00AF, 16'h00A6, 16'h00A5, 16'h20A9, 16'h0000,
    16'h2502, 16'h2190, 16'h2191, 16'h2192, 16'h2193, 16'h25A0, 16'h25CB, 16'h0000
  };

  function automatic logic [1:0] mod3(input logic [3:0] v);
    logic [1:0] r;
    unique case (v)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       r = 2'd1;
      default:                              r = 2'd2;
    endcase
    return r;
  endfunction

endpackage

/* rtl/ucn_front.sv */
// Front end: accepts input items, tracks CR/LF pairing and classifies each code point
// into a run of up to three results. Depends on ucn_pkg.
module ucn_front
  import ucn_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  in_item_t     in_item_i,
  input  logic         push,
  input  fifo_status_t fifo_st_i,
  output logic         wr_en_o,
  output run_t         wr_run_o
);

  logic cr_pending_q, cr_pending_d;
  logic accept;
  logic drop;
  logic two;
  cp_t  c;
  cp_t  s0;
  cp_t  s1;
  logic last;
  logic even;
  logic [1:0] m3;
  logic in_3070, in_30d0;
  logic [HalfKanaIdxW-1:0] kana_idx;

  assign c      = in_item_i.code_point;
  assign last   = in_item_i.last_in_string;
  assign accept = push && !fifo_st_i.full;
  assign drop   = cr_pending_q && (c == CpLf);
  assign even   = !c[0];
  assign m3     = mod3(c[3:0]);
  assign in_3070 = (c >= 21'h3070) && (c <= 21'h307D);
  assign in_30d0 = (c >= 21'h30D0) && (c <= 21'h30DD);
  assign kana_idx = HalfKanaIdxW'(c - HalfKanaLo);

  always_comb begin
    two = 1'b0;
    s1  = CpNul;
    priority if (((c >= 21'h0A) && (c <= 21'h0D)) || (c == 21'h85) ||
                 (c == 21'h2028) || (c == 21'h2029)) begin
      s0 = CpLf;
    end else if ((c == 21'h09) || (c == CpSpace) || (c == 21'h1680) ||
                 ((c >= 21'h2000) && (c <= 21'h200A) && (c != CpFigSpace)) ||
                 (c == 21'h205F) || (c == 21'h3000) || (c == 21'h180E)) begin
      s0 = CpSpace;
    end else if ((c >= CpZwsp) && (c <= 21'h200D)) begin
      s0 = CpZwsp;
    end else if ((c == CpNbsp) || (c == CpFigSpace) || (c == 21'h202F)) begin
      s0 = CpNbsp;
    end else if ((c == CpWordJoin) || (c == 21'hFEFF)) begin
      s0 = CpWordJoin;
    end else if (((c >= 21'h304B) && (c <= 21'h3062) && even) ||
                 ((c >= 21'h30AB) && (c <= 21'h30C2) && even) ||
                 (c == 21'h3065) || (c == 21'h3067) || (c == 21'h3069) ||
                 (c == 21'h309E) || (c == 21'h30C5) || (c == 21'h30C7) ||
                 (c == 21'h30C9) || (c == 21'h30FE) ||
                 ((in_3070 || in_30d0) && (m3 == 2'd0))) begin
      s0  = c - 21'd1;
      s1  = CpVoiced;
      two = 1'b1;
    end else if ((in_3070 || in_30d0) && (m3 == 2'd1)) begin
      s0  = c - 21'd2;
      s1  = CpSemiVoiced;
      two = 1'b1;
    end else if ((c >= 21'h30F7) && (c <= 21'h30FA)) begin
      s0  = c - 21'd8;
      s1  = CpVoiced;
      two = 1'b1;
    end else if ((c == 21'h3094) || (c == 21'h30F4)) begin
      s0  = c - VuOff;
      s1  = CpVoiced;
      two = 1'b1;
    end else if ((c == 21'h3099) || (c == 21'h309A)) begin
      s0 = c + 21'd2;
    end else if ((c >= 21'hFF01) && (c <= 21'hFF5E)) begin
      s0 = c - FullwidthOff;
    end else if ((c >= HalfKanaLo) && (c <= 21'hFFA0)) begin
      s0 = {5'd0, HalfKanaRom[kana_idx]};
    end else if ((c >= WidthSymLo) && (c <= 21'hFFEF)) begin
      s0 = {5'd0, WidthSymRom[c[3:0]]};
    end else begin
      s0 = c;
    end
  end

  always_comb begin
    if (drop) begin
      wr_run_o.cp0 = CpNul;
      wr_run_o.cp1 = CpNul;
      wr_run_o.cnt = {1'b0, last};
    end else begin
      wr_run_o.cp0 = s0;
      wr_run_o.cp1 = s1;
      wr_run_o.cnt = (two ? 2'd2 : 2'd1) + {1'b0, last};
    end
  end

  assign wr_en_o = accept && (wr_run_o.cnt != 2'd0);

  assign cr_pending_d = accept ? ((c == CpCr) && !last) : cr_pending_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_pending_q <= 1'b0;
    end else begin
      cr_pending_q <= cr_pending_d;
    end
  end

endmodule

/* rtl/ucn_fifo.sv */
// Short run queue between the classifier and the output sequencer.
// Depends on ucn_pkg.
module ucn_fifo
  import ucn_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_en_i,
  input  run_t         wr_run_i,
  input  logic         rd_en_i,
  output run_t         rd_run_o,
  output fifo_status_t st_o
);

  run_t                mem_q [FifoDepth];
  logic [PtrWidth-1:0] wptr_q, wptr_d;
  logic [PtrWidth-1:0] rptr_q, rptr_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                do_wr, do_rd;

  assign st_o.full  = (cnt_q == CntWidth'(FifoDepth));
  assign st_o.empty = (cnt_q == '0);
  assign do_wr      = wr_en_i && !st_o.full;
  assign do_rd      = rd_en_i && !st_o.empty;
  assign rd_run_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_wr ? wptr_q + PtrWidth'(1) : wptr_q;
    rptr_d = do_rd ? rptr_q + PtrWidth'(1) : rptr_q;
    cnt_d  = cnt_q + CntWidth'(do_wr) - CntWidth'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_run_i;
    end
  end

endmodule

/* rtl/ucn_back.sv */
// Back end: walks each queued run into the output register one result per cycle
// while the output register is empty or popped. Depends on ucn_pkg.
module ucn_back
  import ucn_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  run_t         rd_run_i,
  input  fifo_status_t fifo_st_i,
  output logic         rd_en_o,
  output out_item_t    out_item_o,
  output logic         empty,
  input  logic         pop
);

  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;
  logic [1:0] idx_q, idx_d;
  logic       load;
  logic       run_end;

  assign load    = !out_valid_q || pop;
  assign run_end = (idx_q == (rd_run_i.cnt - 2'd1));

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    idx_d       = idx_q;
    rd_en_o     = 1'b0;
    if (load) begin
      out_valid_d = !fifo_st_i.empty;
      unique case (idx_q)
        2'd0:    out_d.out_code_point = rd_run_i.cp0;
        2'd1:    out_d.out_code_point = rd_run_i.cp1;
        default: out_d.out_code_point = CpNul;
      endcase
      out_d.last_of_run = run_end;
      if (!fifo_st_i.empty) begin
        if (run_end) begin
          rd_en_o = 1'b1;
          idx_d   = 2'd0;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_item_o = out_q;
  assign empty      = !out_valid_q;

`ifndef ASSERT_OFF
  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 2'd0) |-> !fifo_st_i.empty)
    else $error("run in progress with empty queue");
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fifo_st_i.empty |-> (idx_q < rd_run_i.cnt))
    else $error("run index past run length");
  a_no_empty_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fifo_st_i.empty |-> (rd_run_i.cnt != 2'd0))
    else $error("empty run queued");
  a_pop_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_o |=> (idx_q == 2'd0))
    else $error("index not reset after run");
`endif

endmodule

/* rtl/unicode_char_normalizer.sv */
// Top level of the Unicode character normalizer: classifier, run queue, sequencer.
// Depends on ucn_pkg, ucn_front, ucn_fifo, ucn_back.
//
// Usage:
//   Input side is a queue write port: drive in_item_i and push; the item is taken
//   on a clock edge with push high and full low. Output side is a queue read port:
//   while empty is low the oldest result sits on out_item_o, and it is taken on an
//   edge with pop high.
//   Each input yields one to three results (base, voicing mark, terminator when
//   last_in_string is set); an LF right after a CR yields none unless it ends the
//   string. last_of_run flags the final result of each input.
//   The first result of an item passes the run queue and then the output register
//   on its way to out_item_o, where it waits until it is popped.
//   Throughput: one result per cycle while pop is held, set by the single output
//   register; inputs yielding one result then sustain one item per cycle, while
//   longer runs are walked out one result at a time. A four-entry run queue absorbs
//   the difference and asserts full when it fills.
//   Reset empties the queue and clears the output valid flag, run index and CR flag.
//   When the receiver stalls, results hold, the queue fills and full rises.
module unicode_char_normalizer
  import ucn_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  logic      push,
  output logic      full,
  output out_item_t out_item_o,
  output logic      empty,
  input  logic      pop
);

  fifo_status_t fifo_st;
  logic         wr_en;
  run_t         wr_run;
  logic         rd_en;
  run_t         rd_run;

  ucn_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_item_i (in_item_i),
    .push      (push),
    .fifo_st_i (fifo_st),
    .wr_en_o   (wr_en),
    .wr_run_o  (wr_run)
  );

  ucn_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_run_i (wr_run),
    .rd_en_i  (rd_en),
    .rd_run_o (rd_run),
    .st_o     (fifo_st)
  );

  ucn_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_run_i   (rd_run),
    .fifo_st_i  (fifo_st),
    .rd_en_o    (rd_en),
    .out_item_o (out_item_o),
    .empty      (empty),
    .pop        (pop)
  );

  assign full = fifo_st.full;

endmodule
